[rtl/core/csalu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_pkg
// Opcodes, status codes and the per-stage token of the checked ALU.
// ----------------------------------------------------------------------------
package csalu_pkg;

    localparam int unsigned WordW = 64;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_MOD      = 4'd4;
    localparam logic [3:0] OP_NEG      = 4'd5;
    localparam logic [3:0] OP_ABS      = 4'd6;
    localparam logic [3:0] OP_SQR      = 4'd7;
    localparam logic [3:0] OP_MIN      = 4'd8;
    localparam logic [3:0] OP_MAX      = 4'd9;
    localparam logic [3:0] OP_DIVFLOOR = 4'd10;
    localparam logic [3:0] OP_DIVCEIL  = 4'd11;
    localparam logic [3:0] OP_INC      = 4'd12;
    localparam logic [3:0] OP_DEC      = 4'd13;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_BADMOD  = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [3:0]       opcode;
        logic             is_div;    // uses the divider result
        logic             is_mul;    // uses the product result
        logic             neg;       // result sign of mul or div
        logic             a_neg;
        logic [WordW-1:0] rem;       // partial remainder
        logic [WordW-1:0] quo;       // quotient bits, dividend shifted in
        logic [WordW-1:0] divisor;   // magnitude of divisor
        logic [WordW-1:0] prod;      // multiplier product bits
        logic [WordW-1:0] mcand;     // multiplicand magnitude
        logic [WordW-1:0] mplier;    // remaining multiplier bits
        logic             mul_ovf;
        logic [WordW-1:0] value;     // result of single-step ops
        logic [1:0]       status;
        logic             lt;
        logic             eq;
    } token_t;

endpackage

[rtl/core/csalu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface csalu_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/csalu_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_cell
// One chain cell: one restoring divide bit and one shift-add multiply bit.
// ----------------------------------------------------------------------------
module csalu_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  csalu_pkg::token_t   tok_in,
    output csalu_pkg::token_t   tok_out
);
    import csalu_pkg::*;

    token_t          tok_reg;
    token_t          tok_next;
    logic [WordW:0]  trial;
    logic [WordW:0]  rem_sh;
    logic [WordW:0]  sum;

    always_comb
    begin
        tok_next = tok_in;
        rem_sh   = {tok_in.rem, tok_in.quo[WordW-1]};
        trial    = rem_sh - {1'b0, tok_in.divisor};
        if (!trial[WordW])
        begin
            tok_next.rem = trial[WordW-1:0];
            tok_next.quo = {tok_in.quo[WordW-2:0], 1'b1};
        end
        else
        begin
            tok_next.rem = rem_sh[WordW-1:0];
            tok_next.quo = {tok_in.quo[WordW-2:0], 1'b0};
        end
        // multiply from the top bit down: prod = 2*prod + bit*mcand
        sum = {tok_in.prod, 1'b0}
            + (tok_in.mplier[WordW-1] ? {1'b0, tok_in.mcand} : '0);
        tok_next.mul_ovf = tok_in.mul_ovf | tok_in.prod[WordW-1] | sum[WordW];
        tok_next.prod    = sum[WordW-1:0];
        tok_next.mplier  = {tok_in.mplier[WordW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
endmodule

[rtl/core/csalu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_front
// Decode a transaction: single-step ops, error checks and chain seeding.
// ----------------------------------------------------------------------------
module csalu_front (
    input  logic                   valid,
    input  logic [3:0]             opcode,
    input  logic signed [63:0]     operand_a,
    input  logic signed [63:0]     operand_b,
    output csalu_pkg::token_t      tok
);
    import csalu_pkg::*;

    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] ma;
    logic [WordW-1:0] mb;
    logic [WordW-1:0] r;
    logic [WordW-1:0] minv;
    logic             lt;
    logic             div_op;

    assign a    = operand_a;
    assign b    = operand_b;
    assign minv = {1'b1, {(WordW-1){1'b0}}};
    assign ma   = a[WordW-1] ? (~a + 1'b1) : a;
    assign mb   = b[WordW-1] ? (~b + 1'b1) : b;
    assign lt   = operand_a < operand_b;
    assign div_op = (opcode == OP_DIV) || (opcode == OP_DIVFLOOR)
                 || (opcode == OP_DIVCEIL);

    always_comb
    begin
        tok         = '0;
        tok.valid   = valid;
        tok.opcode  = opcode;
        tok.lt      = lt;
        tok.eq      = (a == b);
        tok.a_neg   = a[WordW-1];
        tok.quo     = ma;
        tok.divisor = mb;
        tok.mcand   = ma;
        tok.mplier  = mb;
        tok.neg     = a[WordW-1] ^ b[WordW-1];
        tok.status  = ST_OK;
        r           = '0;
        case (opcode)
            OP_ADD:
            begin
                r = a + b;
                if (((a ^ r) & (b ^ r)) >> (WordW-1) != '0) tok.status = ST_RANGE;
                else tok.value = r;
            end
            OP_SUB:
            begin
                r = a - b;
                if (((a ^ b) & (a ^ r)) >> (WordW-1) != '0) tok.status = ST_RANGE;
                else tok.value = r;
            end
            OP_MUL:
                tok.is_mul = 1'b1;
            OP_SQR:
            begin
                tok.is_mul = 1'b1;
                tok.mplier = ma;
                tok.neg    = 1'b0;
            end
            OP_DIV, OP_DIVFLOOR, OP_DIVCEIL:
            begin
                if (b == '0) tok.status = ST_DIVZERO;
                else if (a == minv && b == '1) tok.status = ST_RANGE;
                else tok.is_div = 1'b1;
            end
            OP_MOD:
            begin
                if (b == '0 || b[WordW-1]) tok.status = ST_BADMOD;
                else tok.is_div = 1'b1;
            end
            OP_NEG:
            begin
                if (a == minv) tok.status = ST_RANGE;
                else tok.value = ~a + 1'b1;
            end
            OP_ABS:
            begin
                if (a == minv) tok.status = ST_RANGE;
                else tok.value = ma;
            end
            OP_MIN:
                tok.value = lt ? a : b;
            OP_MAX:
                tok.value = lt ? b : a;
            OP_INC:
            begin
                if (a == ~minv) tok.status = ST_RANGE;
                else tok.value = a + 1'b1;
            end
            OP_DEC:
            begin
                if (a == minv) tok.status = ST_RANGE;
                else tok.value = a - 1'b1;
            end
            default:
                tok.value = '0;
        endcase
        if (div_op && !tok.is_div)
        begin
            tok.value = '0;
        end
    end
endmodule

[rtl/core/csalu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_back
// Finish a transaction: sign, rounding and range check of chain results.
// ----------------------------------------------------------------------------
module csalu_back (
    input  csalu_pkg::token_t   tok,
    output logic [63:0]         value,
    output logic [1:0]          status
);
    import csalu_pkg::*;

    logic [WordW-1:0] q;
    logic [WordW-1:0] minv;
    logic             rnz;

    assign minv = {1'b1, {(WordW-1){1'b0}}};
    assign rnz  = (tok.rem != '0);

    always_comb
    begin
        value  = tok.value;
        status = tok.status;
        q      = tok.quo;
        if (tok.is_div)
        begin
            if (tok.opcode == OP_MOD)
            begin
                value = tok.a_neg ? (~tok.rem + 1'b1) : tok.rem;
            end
            else
            begin
                if (rnz && ((tok.opcode == OP_DIVFLOOR && tok.neg)
                         || (tok.opcode == OP_DIVCEIL && !tok.neg)))
                begin
                    q = tok.quo + 1'b1;
                end
                value = tok.neg ? (~q + 1'b1) : q;
            end
        end
        else if (tok.is_mul)
        begin
            if (tok.mul_ovf || (tok.neg ? (tok.prod > minv) : tok.prod[WordW-1]))
            begin
                status = ST_RANGE;
                value  = '0;
            end
            else
            begin
                value = tok.neg ? (~tok.prod + 1'b1) : tok.prod;
            end
        end
    end
endmodule

[rtl/core/checked_signed_integer_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_signed_integer_alu
// Signed 64-bit ALU with range, zero-divisor and modulus checks.
//
//   channel   dir   payload
//   in_ch     in    opcode, operand_a, operand_b
//   out_ch    out   value, status, a_less_than_b, a_equals_b
//
// The pipeline is a decode register, 64 chain cells and an output register.
// One transaction per cycle while out_ch is not stalled; each cell retires
// one divide and one multiply bit, so the 64-cell chain sets latency, not rate.
// Reset clears the valid bits only.
// Output stall freezes the whole chain; in_ch.ready follows it.
// ----------------------------------------------------------------------------
module checked_signed_integer_alu (
    input  logic clk,
    input  logic rst_n,
    csalu_if.sink   in_ch,
    csalu_if.source out_ch
);
    import csalu_pkg::*;

    localparam int unsigned Depth = WordW;

    token_t tok_front;
    token_t seed_reg;
    token_t chain [Depth+1];
    logic   advance;
    logic [63:0] value;
    logic [1:0]  status;
    logic        out_valid_reg;
    logic [67:0] out_data_reg;

    assign advance = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    csalu_front u_front (
        .valid     (in_ch.valid),
        .opcode    (in_ch.data.opcode),
        .operand_a (in_ch.data.operand_a),
        .operand_b (in_ch.data.operand_b),
        .tok       (tok_front)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            seed_reg <= tok_front;
        end
    end

    assign chain[0] = seed_reg;

    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        csalu_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    csalu_back u_back (
        .tok    (chain[Depth]),
        .value  (value),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[Depth].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {value, status, chain[Depth].lt, chain[Depth].eq};
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.data.value         = out_data_reg[67:4];
    assign out_ch.data.status        = out_data_reg[3:2];
    assign out_ch.data.a_less_than_b = out_data_reg[1];
    assign out_ch.data.a_equals_b    = out_data_reg[0];

`ifndef NO_ASSERTIONS
    a_stall_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("output dropped under stall");
    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.status != ST_OK |-> out_ch.data.value == '0)
        else $error("nonzero value with error status");
    a_lt_eq_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.data.a_less_than_b && out_ch.data.a_equals_b))
        else $error("less-than and equal both set");
    a_ready_tracks_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("input ready disagrees with output stall");
`endif
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for checked_signed_integer_alu: directed corner
// operations, random mixed traffic with bursty idling on both channels, a
// long output hold-off, a drain pause and a back-to-back streaming phase.
// Every result is compared field by field with an in-order prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import csalu_pkg::*;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } alu_req_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic        a_less_than_b;
        logic        a_equals_b;
    } alu_resp_t;

    localparam logic [3:0]  OP_SPARE_LO = 4'd14;
    localparam logic [3:0]  OP_SPARE_HI = 4'd15;
    localparam logic [63:0] MIN_VAL     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINUS_ONE   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 80;

    logic clk;
    logic rst_n;

    csalu_if #(.payload_t(alu_req_t))  in_if ();
    csalu_if #(.payload_t(alu_resp_t)) out_if ();

    checked_signed_integer_alu dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if.sink),
        .out_ch (out_if.source)
    );

    alu_resp_t expected_results[$];
    int        mismatches;
    int        cycles;
    bit        idle_en;
    bit        hold_request;
    int        hold_left;
    int        stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic bit fits64(logic signed [127:0] x);
        logic signed [127:0] ext;
        ext = $signed(x[63:0]);
        return ext == x;
    endfunction

    function automatic alu_resp_t alu_predict(logic [3:0] op, logic [63:0] a_u,
                                              logic [63:0] b_u);
        alu_resp_t           res;
        logic signed [63:0]  a;
        logic signed [63:0]  b;
        logic signed [63:0]  q;
        logic signed [63:0]  r;
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] wide;
        logic [1:0]          st;
        a = a_u;
        b = b_u;
        wa = a;
        wb = b;
        st = ST_OK;
        wide = '0;
        res.a_less_than_b = a < b;
        res.a_equals_b = a == b;
        case (op)
            OP_ADD:   wide = wa + wb;
            OP_SUB:   wide = wa - wb;
            OP_MUL:   wide = wa * wb;
            OP_SQR:   wide = wa * wa;
            OP_NEG:   wide = -wa;
            OP_ABS:   wide = (a < 0) ? -wa : wa;
            OP_INC:   wide = wa + 1;
            OP_DEC:   wide = wa - 1;
            OP_MIN:   wide = (a < b) ? wa : wb;
            OP_MAX:   wide = (a < b) ? wb : wa;
            OP_MOD:
            begin
                if (b <= 0)
                    st = ST_BADMOD;
                else
                    wide = a % b;
            end
            OP_DIV, OP_DIVFLOOR, OP_DIVCEIL:
            begin
                if (b == 0)
                    st = ST_DIVZERO;
                else if (a_u == MIN_VAL && b_u == MINUS_ONE)
                    st = ST_RANGE;
                else
                begin
                    q = a / b;
                    r = a % b;
                    if (r != 0 && op == OP_DIVFLOOR && ((a < 0) != (b < 0)))
                        q = q - 1;
                    if (r != 0 && op == OP_DIVCEIL && ((a < 0) == (b < 0)))
                        q = q + 1;
                    wide = q;
                end
            end
            default: wide = '0;
        endcase
        if (st == ST_OK && !fits64(wide))
            st = ST_RANGE;
        res.status = st;
        res.value = (st == ST_OK) ? wide[63:0] : 64'd0;
        return res;
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return 64'(signed'($urandom_range(0, 6)) - 3);
            3: return MIN_VAL + 64'($urandom_range(0, 3));
            4: return MAX_VAL - 64'($urandom_range(0, 3));
            5: return 64'(signed'($urandom));
            6: return {32'd0, $urandom} >> $urandom_range(0, 31);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= '{opcode: op, operand_a: a, operand_b: b};
        do
            @(posedge clk);
        while (!in_if.ready);
        expected_results.push_back(alu_predict(op, a, b));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [3:0] op;
        for (int i = 0; i <= 15; i++)
        begin
            op = 4'(i);
            send_item(op, MIN_VAL, MINUS_ONE);
        end
        send_item(OP_ADD, MAX_VAL, 64'd1);
        send_item(OP_SUB, MIN_VAL, 64'd1);
        send_item(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
        send_item(OP_MUL, 64'hFFFF_FFFF_0000_0000, 64'h8000_0000);
        send_item(OP_DIV, 64'd0, 64'd0);
        send_item(OP_DIVFLOOR, 64'd7, 64'd0);
        send_item(OP_DIVCEIL, 64'd7, 64'd2);
        send_item(OP_DIVFLOOR, MINUS_ONE - 64'd6, 64'd2);
        send_item(OP_MOD, MINUS_ONE - 64'd6, 64'd3);
        send_item(OP_MOD, 64'd7, 64'd0);
        send_item(OP_SQR, 64'h0000_0000_B504_F334, 64'd0);
        send_item(OP_INC, MAX_VAL, MAX_VAL);
        send_item(OP_SPARE_LO, MAX_VAL, MIN_VAL);
        send_item(OP_SPARE_HI, 64'd5, 64'd5);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
    endtask

    task automatic test_output_hold();
        hold_request = 1'b1;
        test_random(200);
    endtask

    task automatic test_drain_pause();
        test_random(50);
        wait_drained();
        test_random(50);
    endtask

    task automatic test_streaming();
        idle_en = 1'b0;
        test_random(300);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            hold_left = 0;
            stall_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_if.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        alu_resp_t got;
        alu_resp_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = out_if.data;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%h status=%0d lt=%b eq=%b",
                             got.value, got.status, got.a_less_than_b, got.a_equals_b);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.value !== want.value || got.status !== want.status
                    || got.a_less_than_b !== want.a_less_than_b
                    || got.a_equals_b !== want.a_equals_b)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp value=%h status=%0d lt=%b eq=%b,",
                                  " got value=%h status=%0d lt=%b eq=%b"},
                                 want.value, want.status, want.a_less_than_b,
                                 want.a_equals_b, got.value, got.status,
                                 got.a_less_than_b, got.a_equals_b);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("checked_signed_integer_alu regression: fail");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        idle_en = 1'b1;
        hold_request = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1200);
        test_output_hold();
        test_drain_pause();
        test_streaming();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("checked_signed_integer_alu regression: pass");
        else
            $display("checked_signed_integer_alu regression: fail");
        $finish;
    end
endmodule

[sim.f]
rtl/core/csalu_pkg.sv
rtl/core/csalu_if.sv
rtl/core/csalu_cell.sv
rtl/core/csalu_front.sv
rtl/core/csalu_back.sv
rtl/core/checked_signed_integer_alu.sv
sim/tb_top.sv
